@@ design/tcct_pkg.sv @@
// shared types, control word bits and codes of the three-channel compare timer
package tcct_pkg;

    localparam int NUM_TIMERS = 3;
    localparam int TIMER_W    = 2;

    // control word bit positions
    localparam int CW_EN   = 15;
    localparam int CW_INT  = 13;
    localparam int CW_RIU  = 12;
    localparam int CW_RTG  = 4;
    localparam int CW_P    = 3;
    localparam int CW_EXT  = 2;
    localparam int CW_ALT  = 1;
    localparam int CW_CONT = 0;

    // item kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register select codes
    localparam logic [1:0] REG_CTRL  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_CMPA  = 2'd2;
    localparam logic [1:0] REG_CMPB  = 2'd3;

    // timer indexes
    localparam logic [TIMER_W-1:0] TMR_0 = 2'd0;
    localparam logic [TIMER_W-1:0] TMR_1 = 2'd1;
    localparam logic [TIMER_W-1:0] TMR_2 = 2'd2;

    // one memory entry: all state of one timer
    typedef struct packed {
        logic [15:0] cw;
        logic [15:0] cnt;
        logic [15:0] cmpa;
        logic [15:0] cmpb;
    } t_entry;

    // what the stage after the memory read needs to know about the item
    typedef struct packed {
        logic               op;
        logic               step;
        logic [TIMER_W-1:0] timer;
        logic [1:0]         rsel;
        logic [15:0]        wval;
        logic [2:0]         levels;
        logic               wr_ok;
    } t_step_ctl;

    typedef struct packed {
        logic               irq_valid;
        logic [TIMER_W-1:0] irq_timer;
        logic [7:0]         irq_vector;
        logic               stepped;
        logic [15:0]        count;
    } t_result;

    function automatic logic [7:0] irq_vector_of(input logic [TIMER_W-1:0] t);
        logic [7:0] v;
        unique case (t)
            TMR_0:   v = 8'h08;
            TMR_1:   v = 8'h12;
            TMR_2:   v = 8'h13;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ design/tcct_step.sv @@
// modify step of one timer entry: gating, increment, compare, register writes
module tcct_step (
    input  tcct_pkg::t_step_ctl i_ctl,
    input  tcct_pkg::t_entry    i_entry,
    input  tcct_pkg::t_entry    i_t2,
    output tcct_pkg::t_entry    o_entry,
    output logic                o_wr_en,
    output tcct_pkg::t_result   o_result
);

    logic [15:0] cw;
    logic [15:0] inc;
    logic        gate;
    logic        match;

    always_comb begin
        o_entry  = i_entry;
        o_result = '0;
        o_wr_en  = 1'b0;
        cw       = i_entry.cw;
        inc      = i_entry.cnt + 16'd1;
        match    = 1'b0;
        gate     = i_entry.cw[tcct_pkg::CW_EN]
                   && (i_entry.cw[tcct_pkg::CW_EXT]
                       || ((i_entry.cw[tcct_pkg::CW_RTG] || i_ctl.levels[i_ctl.timer])
                           && (!i_entry.cw[tcct_pkg::CW_P] || i_t2.cnt == i_t2.cmpa)));

        if (i_ctl.op == tcct_pkg::OP_WRITE) begin
            o_wr_en = i_ctl.wr_ok;
            unique case (i_ctl.rsel)
                tcct_pkg::REG_CTRL:  o_entry.cw   = i_ctl.wval;
                tcct_pkg::REG_COUNT: o_entry.cnt  = i_ctl.wval;
                tcct_pkg::REG_CMPA:  o_entry.cmpa = i_ctl.wval;
                default:             o_entry.cmpb = i_ctl.wval;
            endcase
        end else if (i_ctl.step && gate) begin
            o_wr_en = 1'b1;
            if (cw[tcct_pkg::CW_ALT]) begin
                if (cw[tcct_pkg::CW_RIU]) begin
                    match = (inc == i_entry.cmpb);
                    if (match) begin
                        cw[tcct_pkg::CW_RIU] = 1'b0;
                        if (!cw[tcct_pkg::CW_CONT]) cw[tcct_pkg::CW_EN] = 1'b0;
                    end
                end else begin
                    match = (inc == i_entry.cmpa);
                    if (match) cw[tcct_pkg::CW_RIU] = 1'b1;
                end
            end else begin
                match = (inc == i_entry.cmpa);
                if (match && !cw[tcct_pkg::CW_CONT]) cw[tcct_pkg::CW_EN] = 1'b0;
            end
            o_entry.cw       = cw;
            o_entry.cnt      = match ? 16'd0 : inc;
            o_result.stepped = 1'b1;
            o_result.count   = match ? 16'd0 : inc;
            if (match && cw[tcct_pkg::CW_INT]) begin
                o_result.irq_valid  = 1'b1;
                o_result.irq_timer  = i_ctl.timer;
                o_result.irq_vector = tcct_pkg::irq_vector_of(i_ctl.timer);
            end
        end
    end

endmodule

@@ design/three_channel_compare_timer_top.sv @@
// top level of the three-channel compare timer: phase counter, timer memory, output register
//
// Three 16-bit up-counting timers with a control word and compare registers A
// and B each. Tick items (tuser 0) advance a phase counter that runs from 0 to
// PHASE_PERIOD-1; the tick that brings it to 2, 4 or 6 steps timer 0, 1 or 2.
// Write items (tuser 1) load the control, count, compare A or compare B register
// of the selected timer; timer select 3 is ignored. Every item returns exactly
// one result item. The block takes one item per clock while the result sink keeps
// up; a stalled sink holds off the input. A result passes the register after the
// memory read and then the output register. The timer state lives in a
// small memory with a registered read: an item reads its timer entry (and
// timer 2's entry for the prescale check) when accepted, modifies it in the
// next cycle and writes it back as the result moves into the output register.
// A write-back on the same edge as a read of the same entry is forwarded.
// Reset clears the state through per-entry valid bits, so no clearing pass is
// needed and the block is ready right after reset.
module three_channel_compare_timer_top #(
    parameter int PHASE_PERIOD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // timer_select[1:0], register_select[3:2],
                                    // write_value[19:4], input_levels[22:20], zero pad
    input  logic [0:0]  i_s_tuser,  // opcode[0]
    // result item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // irq_timer[1:0], irq_vector[9:2],
                                    // stepped_count[25:10], zero pad
    output logic [1:0]  o_m_tuser   // irq_valid[0], stepped_timer_valid[1]
);

    // phase counter must hold PHASE_PERIOD itself right after the increment
    localparam int PW = $clog2(PHASE_PERIOD + 1);

    // input fields
    logic                         in_op;
    logic [tcct_pkg::TIMER_W-1:0] in_tsel;
    logic [1:0]                   in_rsel;
    logic [15:0]                  in_wval;
    logic [2:0]                   in_levels;

    assign in_op     = i_s_tuser[0];
    assign in_tsel   = i_s_tdata[1:0];
    assign in_rsel   = i_s_tdata[3:2];
    assign in_wval   = i_s_tdata[19:4];
    assign in_levels = i_s_tdata[22:20];

    // handshake and pipeline control
    logic in_acc;
    logic s1_adv;
    logic r_s1_valid;
    logic r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // phase counter, advanced by ticks at acceptance
    logic [PW-1:0]                r_phase;
    logic [PW-1:0]                n_phase;
    logic [PW-1:0]                phase_inc;
    logic                         tick_step;
    logic [tcct_pkg::TIMER_W-1:0] tick_timer;

    always_comb begin
        phase_inc  = r_phase + PW'(1);
        tick_step  = 1'b1;
        tick_timer = tcct_pkg::TMR_0;
        priority if (phase_inc == PW'(2)) begin
            tick_timer = tcct_pkg::TMR_0;
        end else if (phase_inc == PW'(4)) begin
            tick_timer = tcct_pkg::TMR_1;
        end else if (phase_inc == PW'(6)) begin
            tick_timer = tcct_pkg::TMR_2;
        end else begin
            tick_step = 1'b0;
        end
        n_phase = (phase_inc >= PW'(PHASE_PERIOD)) ? '0 : phase_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_acc && in_op == tcct_pkg::OP_TICK) begin
            r_phase <= n_phase;
        end
    end

    // read address: stepped timer for a tick, selected timer for a write;
    // timer select 3 reads entry 0 but never writes
    logic [tcct_pkg::TIMER_W-1:0] rd_addr;
    logic                         wr_ok;

    assign wr_ok   = (in_tsel != 2'd3);
    assign rd_addr = (in_op == tcct_pkg::OP_TICK) ? tick_timer
                   : (wr_ok ? in_tsel : tcct_pkg::TMR_0);

    // timer memory, one entry per timer
    tcct_pkg::t_entry             r_mem [tcct_pkg::NUM_TIMERS];
    logic [tcct_pkg::NUM_TIMERS-1:0] r_mem_vld;
    tcct_pkg::t_entry             r_rd_a;
    tcct_pkg::t_entry             r_rd_b;
    logic                         r_rd_a_vld;
    logic                         r_rd_b_vld;

    // stage after the read
    tcct_pkg::t_step_ctl r_s1_ctl;
    tcct_pkg::t_entry    ent_a;
    tcct_pkg::t_entry    ent_b;
    tcct_pkg::t_entry    wr_entry;
    logic                wr_en;
    tcct_pkg::t_result   step_res;

    // last write-back, for a read issued on the same edge
    logic                         r_fwd_vld;
    logic [tcct_pkg::TIMER_W-1:0] r_fwd_addr;
    tcct_pkg::t_entry             r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a     <= r_mem[rd_addr];
            r_rd_a_vld <= r_mem_vld[rd_addr];
            r_rd_b     <= r_mem[tcct_pkg::TMR_2];
            r_rd_b_vld <= r_mem_vld[tcct_pkg::TMR_2];
            r_s1_ctl   <= '{op: in_op, step: tick_step, timer: rd_addr, rsel: in_rsel,
                            wval: in_wval, levels: in_levels, wr_ok: wr_ok};
        end
        if (s1_adv && wr_en) begin
            r_mem[r_s1_ctl.timer] <= wr_entry;
            r_fwd_addr            <= r_s1_ctl.timer;
            r_fwd_data            <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld  <= '0;
            r_fwd_vld  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s1_adv && wr_en) begin
                r_mem_vld[r_s1_ctl.timer] <= 1'b1;
                r_fwd_vld                 <= 1'b1;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // an entry never written reads as its reset value of zero
    always_comb begin
        if (r_fwd_vld && r_fwd_addr == r_s1_ctl.timer) begin
            ent_a = r_fwd_data;
        end else begin
            ent_a = r_rd_a_vld ? r_rd_a : '0;
        end
        if (r_fwd_vld && r_fwd_addr == tcct_pkg::TMR_2) begin
            ent_b = r_fwd_data;
        end else begin
            ent_b = r_rd_b_vld ? r_rd_b : '0;
        end
    end

    tcct_step u_step (
        .i_ctl    (r_s1_ctl),
        .i_entry  (ent_a),
        .i_t2     (ent_b),
        .o_entry  (wr_entry),
        .o_wr_en  (wr_en),
        .o_result (step_res)
    );

    // output register
    tcct_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.count, r_out.irq_vector, r_out.irq_timer};
    assign o_m_tuser  = {r_out.stepped, r_out.irq_valid};

    // an interrupt only comes from a match, and a match only from a step
    a_irq_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tuser[1])
        else $error("interrupt reported without a timer step");

    // phase counter stays inside its period
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PW'(PHASE_PERIOD))
        else $error("phase counter out of range");

    // no write-back to the unused timer slot
    a_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && wr_en) |-> (r_s1_ctl.timer != 2'd3))
        else $error("write-back to nonexistent timer");

    // a stepped or written entry is written back on the cycle the result is registered
    a_fwd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && wr_en) |=> (r_fwd_vld && r_fwd_data == $past(wr_entry)))
        else $error("forwarding register missed a write-back");

endmodule

@@ tb/tb_three_channel_compare_timer_top.sv @@
// self-checking testbench for the three-channel compare timer: directed rows, random items, predictor
module tb_three_channel_compare_timer_top;
    timeunit 1ns;
    timeprecision 1ps;

    // clocking, reset and run control
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_PERIOD   = 8;
    localparam int RANDOM_ITEMS   = 1875;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SQUEEZE_AT     = 500;   // items accepted before the long sink hold-off
    localparam int SQUEEZE_CYCLES = 80;
    localparam int MAX_REPORTS    = 100;

    // timer select that names no timer, writes to it are dropped
    localparam logic [tcct_pkg::TIMER_W-1:0] TMR_NONE = 2'd3;

    // control word bit masks
    localparam logic [15:0] EN_M   = 16'(1) << tcct_pkg::CW_EN;
    localparam logic [15:0] INT_M  = 16'(1) << tcct_pkg::CW_INT;
    localparam logic [15:0] RTG_M  = 16'(1) << tcct_pkg::CW_RTG;
    localparam logic [15:0] P_M    = 16'(1) << tcct_pkg::CW_P;
    localparam logic [15:0] EXT_M  = 16'(1) << tcct_pkg::CW_EXT;
    localparam logic [15:0] ALT_M  = 16'(1) << tcct_pkg::CW_ALT;
    localparam logic [15:0] CONT_M = 16'(1) << tcct_pkg::CW_CONT;

    // interrupt number of each timer
    localparam logic [7:0] TIMER_VECTOR [tcct_pkg::NUM_TIMERS] = '{8'h08, 8'h12, 8'h13};

    typedef struct packed {
        logic                         op;
        logic [tcct_pkg::TIMER_W-1:0] tsel;
        logic [1:0]                   rsel;
        logic [15:0]                  wval;
        logic [2:0]                   levels;
    } t_timer_item;

    typedef struct packed {
        logic                         irq_valid;
        logic [tcct_pkg::TIMER_W-1:0] irq_timer;
        logic [7:0]                   irq_vector;
        logic                         stepped;
        logic [15:0]                  count;
    } t_timer_result;

    // one directed row: the item, and its result when it is plain to see
    typedef struct packed {
        t_timer_item   item;
        logic          known;
        t_timer_result res;
    } t_stim_row;

    localparam t_timer_result IDLE_RES = '0;

    localparam int DIRECTED_ROWS = 25;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // ticks right after reset: phase 1, then phase 2 with timer 0 disabled
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_2, tcct_pkg::REG_CMPB, 16'hffff, 3'b111},
          1'b1, IDLE_RES},
        // timer 0: external clock, interrupt, one-shot, compare A = 1
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_0, tcct_pkg::REG_CMPA, 16'h0001, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL,
            EN_M | INT_M | EXT_M, 3'b000}, 1'b1, IDLE_RES},
        // write to the missing fourth timer is dropped
        '{'{tcct_pkg::OP_WRITE, TMR_NONE, tcct_pkg::REG_CTRL, 16'hffff, 3'b111},
          1'b1, IDLE_RES},
        // phases 3 to 8, the last one wraps the phase counter, nothing enabled there
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_1, tcct_pkg::REG_COUNT, 16'h5a5a, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b101},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b010},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b111},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b1, IDLE_RES},
        // phase 1, then phase 2: timer 0 counts to 1, matches, interrupts, stops
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b1, '{1'b1, tcct_pkg::TMR_0, 8'h08, 1'b1, 16'h0000}},
        // timer 1: alternate compare, retrigger, continuous, compare A at the top
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_1, tcct_pkg::REG_CMPA, 16'hffff, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_1, tcct_pkg::REG_CMPB, 16'h0001, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_1, tcct_pkg::REG_COUNT, 16'hfffe, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_1, tcct_pkg::REG_CTRL,
            EN_M | INT_M | RTG_M | ALT_M | CONT_M, 3'b000}, 1'b1, IDLE_RES},
        // timer 2: prescale on its own compare A, needs its level
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_2, tcct_pkg::REG_CTRL, EN_M | P_M, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b0, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b0, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b000},
          1'b0, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b100},
          1'b0, IDLE_RES},
        '{'{tcct_pkg::OP_WRITE, tcct_pkg::TMR_2, tcct_pkg::REG_COUNT, 16'hffff, 3'b000},
          1'b1, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b111},
          1'b0, IDLE_RES},
        '{'{tcct_pkg::OP_TICK, tcct_pkg::TMR_0, tcct_pkg::REG_CTRL, 16'h0000, 3'b111},
          1'b0, IDLE_RES}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;  // timer_select[1:0], register_select[3:2],
                             // write_value[19:4], input_levels[22:20], zero pad
    logic [0:0]  i_s_tuser;  // opcode[0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;  // irq_timer[1:0], irq_vector[9:2], stepped_count[25:10], zero pad
    logic [1:0]  o_m_tuser;  // irq_valid[0], stepped_timer_valid[1]

    three_channel_compare_timer_top #(
        .PHASE_PERIOD(PHASE_PERIOD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // predictor copy of the timer state
    int          step_phase;
    logic [15:0] ctl_word [tcct_pkg::NUM_TIMERS];
    logic [15:0] cnt_word [tcct_pkg::NUM_TIMERS];
    logic [15:0] cmp_a    [tcct_pkg::NUM_TIMERS];
    logic [15:0] cmp_b    [tcct_pkg::NUM_TIMERS];

    t_timer_result pending_results [$];  // results owed by the block, oldest first
    int            err_count;
    int            n_accepted;
    int            n_results;
    logic          squeeze_done;

    initial begin
        step_phase   = 0;
        err_count    = 0;
        n_accepted   = 0;
        n_results    = 0;
        squeeze_done = 1'b0;
        for (int t = 0; t < tcct_pkg::NUM_TIMERS; t++) begin
            ctl_word[t] = '0;
            cnt_word[t] = '0;
            cmp_a[t]    = '0;
            cmp_b[t]    = '0;
        end
    end

    // clock: low half, then high half
    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // updates the predicted timer state with one item and returns its result
    function automatic t_timer_result predict_timer_item(input t_timer_item it);
        t_timer_result r;
        int            t;
        logic [15:0]   cw;
        logic          hit;
        r = IDLE_RES;
        if (it.op == tcct_pkg::OP_WRITE) begin
            if (it.tsel <= tcct_pkg::TMR_2) begin
                case (it.rsel)
                    tcct_pkg::REG_CTRL:  ctl_word[it.tsel] = it.wval;
                    tcct_pkg::REG_COUNT: cnt_word[it.tsel] = it.wval;
                    tcct_pkg::REG_CMPA:  cmp_a[it.tsel]    = it.wval;
                    default:             cmp_b[it.tsel]    = it.wval;
                endcase
            end
            return r;
        end
        // tick: advance the phase, test step phases before the wrap
        step_phase++;
        if (step_phase == 2 || step_phase == 4 || step_phase == 6) begin
            t  = step_phase / 2 - 1;
            cw = ctl_word[t];
            // external clock skips both the level and the prescale gate
            if (cw[tcct_pkg::CW_EN] && (cw[tcct_pkg::CW_EXT] ||
                    ((cw[tcct_pkg::CW_RTG] || it.levels[t]) &&
                     (!cw[tcct_pkg::CW_P] ||
                      cnt_word[tcct_pkg::TMR_2] == cmp_a[tcct_pkg::TMR_2])))) begin
                cnt_word[t] = cnt_word[t] + 16'd1;
                if (cw[tcct_pkg::CW_ALT] && cw[tcct_pkg::CW_RIU]) begin
                    // second half of alternate mode, B match ends it
                    hit = (cnt_word[t] == cmp_b[t]);
                    if (hit) begin
                        cw[tcct_pkg::CW_RIU] = 1'b0;
                        if (!cw[tcct_pkg::CW_CONT])
                            cw[tcct_pkg::CW_EN] = 1'b0;
                    end
                end else if (cw[tcct_pkg::CW_ALT]) begin
                    hit = (cnt_word[t] == cmp_a[t]);
                    if (hit)
                        cw[tcct_pkg::CW_RIU] = 1'b1;
                end else begin
                    hit = (cnt_word[t] == cmp_a[t]);
                    if (hit && !cw[tcct_pkg::CW_CONT])
                        cw[tcct_pkg::CW_EN] = 1'b0;
                end
                ctl_word[t] = cw;
                if (hit) begin
                    if (cw[tcct_pkg::CW_INT]) begin
                        r.irq_valid  = 1'b1;
                        r.irq_timer  = tcct_pkg::TIMER_W'(t);
                        r.irq_vector = TIMER_VECTOR[t];
                    end
                    cnt_word[t] = '0;
                end
                r.stepped = 1'b1;
                r.count   = cnt_word[t];
            end
        end
        if (step_phase >= PHASE_PERIOD)
            step_phase = 0;
        return r;
    endfunction

    // idle length for either side: mostly none, some short, a few long,
    // and every 400 items a run of 80 with no idling at all
    function automatic int pick_idle(input int n);
        int r;
        if ((n % 400) < 80)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random item: mostly ticks, writes biased so timers run and match often
    function automatic t_timer_item random_timer_item();
        t_timer_item it;
        int          r;
        it.op     = ($urandom_range(0, 99) < 78) ? tcct_pkg::OP_TICK : tcct_pkg::OP_WRITE;
        it.tsel   = ($urandom_range(0, 15) == 0) ? TMR_NONE
                  : tcct_pkg::TIMER_W'($urandom_range(0, 2));
        it.rsel   = 2'($urandom_range(0, 3));
        it.wval   = 16'($urandom);
        it.levels = 3'($urandom_range(0, 7));
        if (it.op == tcct_pkg::OP_WRITE) begin
            r = $urandom_range(0, 99);
            case (it.rsel)
                tcct_pkg::REG_CTRL: begin
                    if (r < 85)
                        it.wval[tcct_pkg::CW_EN] = 1'b1;
                    if ($urandom_range(0, 1) == 0)
                        it.wval[tcct_pkg::CW_P] = 1'b0;
                end
                tcct_pkg::REG_COUNT: begin
                    if (r < 45)
                        it.wval = 16'($urandom_range(0, 8));
                    else if (r < 75)
                        it.wval = 16'($urandom_range(16'hfff0, 16'hffff));
                end
                default: begin
                    // compare values: small so matches come quickly, some extremes
                    if (r < 70)
                        it.wval = 16'($urandom_range(0, 12));
                    else if (r < 80)
                        it.wval = 16'hffff;
                end
            endcase
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: result %0d %s: got %0h, expected %0h",
                     $realtime, n_results, what, got, want);
    endtask

    // offers one item from the falling edge on, returns at the falling edge
    // after it was taken; the expectation is queued at the accepting edge
    task automatic offer_item(input t_timer_item it, input logic known,
                              input t_timer_result typed_res);
        int            gap;
        t_timer_result want;
        gap = pick_idle(n_accepted);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {1'b0, it.levels, it.wval, it.rsel, it.tsel};
        i_s_tuser  = it.op;
        i_s_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        want = predict_timer_item(it);
        pending_results.push_back(known ? typed_res : want);
        n_accepted++;
        @(negedge i_clk);
    endtask

    // stimulus: reset, directed rows, random items, then wait for the tail
    initial begin : stimulus
        t_timer_item it;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_item(DIRECTED[r].item, DIRECTED[r].known, DIRECTED[r].res);
        repeat (RANDOM_ITEMS) begin
            it = random_timer_item();
            offer_item(it, 1'b0, IDLE_RES);
        end
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_three_channel_compare_timer_top: done, clean");
        else
            $display("tb_three_channel_compare_timer_top: done, errors");
        $finish;
    end

    // result sink: random stalls, plus one long hold-off while items keep coming
    initial begin : result_sink
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!squeeze_done && n_accepted >= SQUEEZE_AT) begin
                squeeze_done = 1'b1;
                i_m_tready   = 1'b0;
                repeat (SQUEEZE_CYCLES - 1) @(negedge i_clk);
            end else begin
                stall = pick_idle(n_results + 200);
                if (stall == 0) begin
                    i_m_tready = 1'b1;
                end else begin
                    i_m_tready = 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
        end
    end

    // result check: every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.irq_valid  = o_m_tuser[0];
            got.stepped    = o_m_tuser[1];
            got.irq_timer  = o_m_tdata[1:0];
            got.irq_vector = o_m_tdata[9:2];
            got.count      = o_m_tdata[25:10];
            if (pending_results.size() == 0) begin
                report_mismatch("arrived with nothing pending", 32'(got), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.irq_valid !== want.irq_valid)
                    report_mismatch("irq_valid", 32'(got.irq_valid), 32'(want.irq_valid));
                if (got.irq_timer !== want.irq_timer)
                    report_mismatch("irq_timer", 32'(got.irq_timer), 32'(want.irq_timer));
                if (got.irq_vector !== want.irq_vector)
                    report_mismatch("irq_vector", 32'(got.irq_vector), 32'(want.irq_vector));
                if (got.stepped !== want.stepped)
                    report_mismatch("stepped_timer_valid", 32'(got.stepped),
                                    32'(want.stepped));
                if (got.count !== want.count)
                    report_mismatch("stepped_count", 32'(got.count), 32'(want.count));
            end
            n_results++;
        end
    end

    // watchdog: too many cycles with no item moving on either side
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_three_channel_compare_timer_top: done, errors");
            $finish;
        end
    end

endmodule

@@ three_channel_compare_timer_top.f @@
design/tcct_pkg.sv
design/tcct_step.sv
design/three_channel_compare_timer_top.sv
tb/tb_three_channel_compare_timer_top.sv
